/* rtl/csl_pkg.sv */
package csl_pkg;

  localparam int SEL_W  = 3;
  localparam int ADDR_W = 12;
  localparam int DATA_W = 16;
  localparam int WID_W  = 11;
  localparam int ID_W   = 12;

  // constant-divisor modulo unit
  localparam int MOD_XW      = 16;
  localparam int MOD_DW      = 14;
  localparam int MOD_MW      = 17;
  localparam int RECIP_SHIFT = 16;

  localparam int WORDS_DEF    = 2048;
  localparam int INITIALS_DEF = 64;
  localparam int FINALS_DEF   = 64;
  localparam int IC_DEF       = 27;
  localparam int FC_DEF       = 32;

  // accepting edge to the edge that takes the result
  localparam int PIPE_LAT = 9;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_t;

  localparam logic [SEL_W-1:0] TS_WORD_MAP    = 3'd0;
  localparam logic [SEL_W-1:0] TS_INIT_STATE  = 3'd1;
  localparam logic [SEL_W-1:0] TS_FINAL_STATE = 3'd2;
  localparam logic [SEL_W-1:0] TS_CONTEXT     = 3'd3;
  localparam logic [SEL_W-1:0] TS_INIT_CLASS  = 3'd4;
  localparam logic [SEL_W-1:0] TS_FINAL_CLASS = 3'd5;

  typedef struct packed {
    cmd_t              command;
    logic [SEL_W-1:0]  table_select;
    logic [ADDR_W-1:0] table_addr;
    logic [DATA_W-1:0] table_data;
    logic [WID_W-1:0]  word_id;
    logic [WID_W-1:0]  prev_word_id;
    logic              prev_valid;
    logic [WID_W-1:0]  next_word_id;
    logic              next_valid;
  } csl_in_t;

  typedef struct packed {
    logic [ID_W-1:0] initial_state0;
    logic [ID_W-1:0] initial_state1;
    logic [ID_W-1:0] final_state0;
    logic [ID_W-1:0] final_state1;
    logic [ID_W-1:0] final_state2;
    logic [ID_W-1:0] final_state3;
    logic [ID_W-1:0] left_context_state;
    logic            left_context_valid;
    logic [ID_W-1:0] right_context_state0;
    logic [ID_W-1:0] right_context_state1;
    logic            right_context_valid;
  } csl_out_t;

endpackage

/* rtl/csl_modc.sv */
module csl_modc import csl_pkg::*; (
  input  logic              clk,
  input  logic [MOD_XW-1:0] x,
  input  logic [MOD_DW-1:0] d,
  input  logic [MOD_MW-1:0] m,
  output logic [MOD_XW-1:0] r
);

  localparam int PW = MOD_XW + MOD_MW;
  localparam int QW = MOD_XW + MOD_DW;

  logic [PW-1:0]     prod_r, prod_nxt;
  logic [QW-1:0]     qd_r, qd_nxt;
  logic [MOD_XW-1:0] xa_r, xb_r;
  logic [MOD_DW-1:0] da_r, db_r;
  logic [MOD_XW-1:0] q, diff, dx, r_r, r_nxt;

  // q estimate is exact or one low, so one correction step suffices
  assign prod_nxt = PW'(x) * PW'(m);
  assign q        = prod_r[RECIP_SHIFT +: MOD_XW];
  assign qd_nxt   = QW'(q) * QW'(da_r);
  assign diff     = xb_r - qd_r[MOD_XW-1:0];
  assign dx       = MOD_XW'(db_r);
  assign r_nxt    = (diff >= dx) ? diff - dx : diff;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    xa_r   <= x;
    da_r   <= d;
    qd_r   <= qd_nxt;
    xb_r   <= xa_r;
    db_r   <= da_r;
    r_r    <= r_nxt;
  end

  assign r = r_r;

endmodule

/* rtl/context_state_id_lookup.sv */
// Result: each accepted lookup strobes out_valid from the output reg; writes give no result.
// Throughput: one item per cycle, writes and lookups mixed; busy is low except in reset.
// Path: input reg, 3-stage constant modulo, word map read, state/class table read,
// context address, context table read, output reg. Table writes land at the read stage.
// Reset: synchronous, active low; clears pipeline valids; table contents are kept.
module context_state_id_lookup import csl_pkg::*; #(
  parameter int WORDS           = WORDS_DEF,
  parameter int INITIALS        = INITIALS_DEF,
  parameter int FINALS          = FINALS_DEF,
  parameter int INITIAL_CLASSES = IC_DEF,
  parameter int FINAL_CLASSES   = FC_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  csl_in_t  in_data,
  output logic     busy,
  output logic     out_valid,
  output csl_out_t out_data
);

  localparam int WMA = $clog2(WORDS);
  localparam int IW  = $clog2(INITIALS);
  localparam int FW  = $clog2(FINALS);
  localparam int ICW = (INITIAL_CLASSES > 1) ? $clog2(INITIAL_CLASSES) : 1;
  localparam int FCW = (FINAL_CLASSES > 1) ? $clog2(FINAL_CLASSES) : 1;
  localparam int CVW = (ICW > FCW) ? ICW : FCW;
  localparam int IC3 = INITIAL_CLASSES * 3;
  localparam int CS  = FINAL_CLASSES * IC3;
  localparam int CSW = $clog2(CS);

  localparam logic [MOD_DW-1:0] D_WORDS = MOD_DW'(WORDS);
  localparam logic [MOD_DW-1:0] D_WM    = MOD_DW'(2 * WORDS);
  localparam logic [MOD_DW-1:0] D_IS    = MOD_DW'(2 * INITIALS);
  localparam logic [MOD_DW-1:0] D_FS    = MOD_DW'(4 * FINALS);
  localparam logic [MOD_DW-1:0] D_CS    = MOD_DW'(CS);
  localparam logic [MOD_DW-1:0] D_INI   = MOD_DW'(INITIALS);
  localparam logic [MOD_DW-1:0] D_FIN   = MOD_DW'(FINALS);
  localparam logic [MOD_DW-1:0] D_IC    = MOD_DW'(INITIAL_CLASSES);
  localparam logic [MOD_DW-1:0] D_FC    = MOD_DW'(FINAL_CLASSES);
  localparam logic [MOD_DW-1:0] D_ONE   = MOD_DW'(1);

  localparam logic [MOD_MW-1:0] M_WORDS = MOD_MW'((2 ** RECIP_SHIFT) / WORDS);
  localparam logic [MOD_MW-1:0] M_WM    = MOD_MW'((2 ** RECIP_SHIFT) / (2 * WORDS));
  localparam logic [MOD_MW-1:0] M_IS    = MOD_MW'((2 ** RECIP_SHIFT) / (2 * INITIALS));
  localparam logic [MOD_MW-1:0] M_FS    = MOD_MW'((2 ** RECIP_SHIFT) / (4 * FINALS));
  localparam logic [MOD_MW-1:0] M_CS    = MOD_MW'((2 ** RECIP_SHIFT) / CS);
  localparam logic [MOD_MW-1:0] M_INI   = MOD_MW'((2 ** RECIP_SHIFT) / INITIALS);
  localparam logic [MOD_MW-1:0] M_FIN   = MOD_MW'((2 ** RECIP_SHIFT) / FINALS);
  localparam logic [MOD_MW-1:0] M_IC    = MOD_MW'((2 ** RECIP_SHIFT) / INITIAL_CLASSES);
  localparam logic [MOD_MW-1:0] M_FC    = MOD_MW'((2 ** RECIP_SHIFT) / FINAL_CLASSES);
  localparam logic [MOD_MW-1:0] M_ONE   = MOD_MW'(2 ** RECIP_SHIFT);

  typedef struct packed {
    cmd_t             cmd;
    logic [SEL_W-1:0] sel;
    logic [ID_W-1:0]  raw;
    logic             pval;
    logic             nval;
  } ctl_t;

  logic     busy_r;
  logic     s0_v_r;
  csl_in_t  s0_r;
  logic [7:1] vld_r;
  ctl_t     ctl_r [1:7];

  // modulo lanes
  logic [MOD_XW-1:0] a_x, b_x, c_x, ra, rb, rc;
  logic [MOD_DW-1:0] a_d, b_d;
  logic [MOD_MW-1:0] a_m, b_m;

  // stage 4
  logic [IW-1:0]     cid4_r, ncid4_r;
  logic [FW-1:0]     vid4_r, pvid4_r;
  logic [ADDR_W-1:0] wa4_r, wa5_r, wa6_r;
  logic [CVW-1:0]    cv4_r;
  logic [IW-1:0]     wm_ini [WORDS];
  logic [FW-1:0]     wm_fin [WORDS];

  // stage 5
  logic [ID_W-1:0] is_ev [INITIALS];
  logic [ID_W-1:0] is_od [INITIALS];
  logic [ID_W-1:0] fs_mem [4][FINALS];
  logic [ICW-1:0]  ic_mem [INITIALS];
  logic [FCW-1:0]  fc_mem [FINALS];
  logic [ID_W-1:0] is5_r [2];
  logic [ID_W-1:0] is6_r [2];
  logic [ID_W-1:0] is7_r [2];
  logic [ID_W-1:0] fs5_r [4];
  logic [ID_W-1:0] fs6_r [4];
  logic [ID_W-1:0] fs7_r [4];
  logic [ICW-1:0]  cc5_r, nc5_r;
  logic [FCW-1:0]  vc5_r, pc5_r;

  // stage 6/7
  logic [CSW-1:0]  el6_r, er06_r, er16_r, el_nxt, er0_nxt, er1_nxt;
  logic [ID_W-1:0] ctx_a [CS];
  logic [ID_W-1:0] ctx_b [CS];
  logic [ID_W-1:0] cl7_r, cr07_r, cr17_r;

  logic     out_valid_r;
  csl_out_t out_r;

  logic wm_we, is_we, fs_we, ic_we, fc_we, ctx_we;

  assign busy = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      s0_v_r      <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      s0_v_r      <= start & ~busy_r;
      vld_r       <= {vld_r[6:1], s0_v_r};
      out_valid_r <= vld_r[7] && (ctl_r[7].cmd == CMD_LOOKUP);
    end
  end

  always_ff @(posedge clk) begin
    s0_r     <= in_data;
    ctl_r[1] <= '{cmd:  s0_r.command,
                  sel:  s0_r.table_select,
                  raw:  s0_r.table_data[ID_W-1:0],
                  pval: s0_r.prev_valid,
                  nval: s0_r.next_valid};
    for (int k = 2; k <= 7; k++) begin
      ctl_r[k] <= ctl_r[k-1];
    end
  end

  // lane A: write data or word id; lane B: write address or prev id; lane C: next id
  always_comb begin
    a_x = s0_r.table_data;
    a_d = D_ONE;
    a_m = M_ONE;
    b_x = MOD_XW'(s0_r.table_addr);
    b_d = D_ONE;
    b_m = M_ONE;
    c_x = MOD_XW'(s0_r.next_word_id);
    if (s0_r.command == CMD_LOOKUP) begin
      a_x = MOD_XW'(s0_r.word_id);
      a_d = D_WORDS;
      a_m = M_WORDS;
      b_x = MOD_XW'(s0_r.prev_word_id);
      b_d = D_WORDS;
      b_m = M_WORDS;
    end else begin
      case (s0_r.table_select)
        TS_WORD_MAP: begin
          a_d = s0_r.table_addr[0] ? D_FIN : D_INI;
          a_m = s0_r.table_addr[0] ? M_FIN : M_INI;
          b_d = D_WM;
          b_m = M_WM;
        end
        TS_INIT_STATE: begin
          b_d = D_IS;
          b_m = M_IS;
        end
        TS_FINAL_STATE: begin
          b_d = D_FS;
          b_m = M_FS;
        end
        TS_CONTEXT: begin
          b_d = D_CS;
          b_m = M_CS;
        end
        TS_INIT_CLASS: begin
          a_d = D_IC;
          a_m = M_IC;
          b_d = D_INI;
          b_m = M_INI;
        end
        TS_FINAL_CLASS: begin
          a_d = D_FC;
          a_m = M_FC;
          b_d = D_FIN;
          b_m = M_FIN;
        end
        default: begin
        end
      endcase
    end
  end

  csl_modc u_mod_a (.clk(clk), .x(a_x), .d(a_d), .m(a_m), .r(ra));
  csl_modc u_mod_b (.clk(clk), .x(b_x), .d(b_d), .m(b_m), .r(rb));
  csl_modc u_mod_c (.clk(clk), .x(c_x), .d(D_WORDS), .m(M_WORDS), .r(rc));

  // word map: even entries hold initial index, odd hold final index
  assign wm_we = vld_r[3] && (ctl_r[3].cmd == CMD_WRITE) && (ctl_r[3].sel == TS_WORD_MAP);

  always_ff @(posedge clk) begin
    cid4_r  <= wm_ini[ra[WMA-1:0]];
    ncid4_r <= wm_ini[rc[WMA-1:0]];
    vid4_r  <= wm_fin[ra[WMA-1:0]];
    pvid4_r <= wm_fin[rb[WMA-1:0]];
    if (wm_we && !rb[0]) begin
      wm_ini[rb[WMA:1]] <= ra[IW-1:0];
    end
    if (wm_we && rb[0]) begin
      wm_fin[rb[WMA:1]] <= ra[FW-1:0];
    end
    wa4_r <= rb[ADDR_W-1:0];
    cv4_r <= ra[CVW-1:0];
  end

  assign is_we = vld_r[4] && (ctl_r[4].cmd == CMD_WRITE) && (ctl_r[4].sel == TS_INIT_STATE);
  assign fs_we = vld_r[4] && (ctl_r[4].cmd == CMD_WRITE) && (ctl_r[4].sel == TS_FINAL_STATE);
  assign ic_we = vld_r[4] && (ctl_r[4].cmd == CMD_WRITE) && (ctl_r[4].sel == TS_INIT_CLASS);
  assign fc_we = vld_r[4] && (ctl_r[4].cmd == CMD_WRITE) && (ctl_r[4].sel == TS_FINAL_CLASS);

  always_ff @(posedge clk) begin
    is5_r[0] <= is_ev[cid4_r];
    is5_r[1] <= is_od[cid4_r];
    if (is_we && !wa4_r[0]) begin
      is_ev[wa4_r[IW:1]] <= ctl_r[4].raw;
    end
    if (is_we && wa4_r[0]) begin
      is_od[wa4_r[IW:1]] <= ctl_r[4].raw;
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_fs
    always_ff @(posedge clk) begin
      fs5_r[g] <= fs_mem[g][vid4_r];
      if (fs_we && (wa4_r[1:0] == 2'(g))) begin
        fs_mem[g][wa4_r[FW+1:2]] <= ctl_r[4].raw;
      end
    end
  end

  always_ff @(posedge clk) begin
    cc5_r <= ic_mem[cid4_r];
    nc5_r <= ic_mem[ncid4_r];
    if (ic_we) begin
      ic_mem[wa4_r[IW-1:0]] <= cv4_r[ICW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    vc5_r <= fc_mem[vid4_r];
    pc5_r <= fc_mem[pvid4_r];
    if (fc_we) begin
      fc_mem[wa4_r[FW-1:0]] <= cv4_r[FCW-1:0];
    end
  end

  // context entry = final class * IC * 3 + initial class * 3 + slot
  assign el_nxt  = CSW'(16'(pc5_r) * 16'(IC3) + 16'(cc5_r) * 16'd3 + 16'd2);
  assign er0_nxt = CSW'(16'(vc5_r) * 16'(IC3) + 16'(nc5_r) * 16'd3);
  assign er1_nxt = CSW'(16'(vc5_r) * 16'(IC3) + 16'(nc5_r) * 16'd3 + 16'd1);

  always_ff @(posedge clk) begin
    el6_r  <= el_nxt;
    er06_r <= er0_nxt;
    er16_r <= er1_nxt;
    wa5_r  <= wa4_r;
    wa6_r  <= wa5_r;
    is6_r  <= is5_r;
    is7_r  <= is6_r;
    fs6_r  <= fs5_r;
    fs7_r  <= fs6_r;
  end

  // two identical copies give three read ports
  assign ctx_we = vld_r[6] && (ctl_r[6].cmd == CMD_WRITE) && (ctl_r[6].sel == TS_CONTEXT);

  always_ff @(posedge clk) begin
    cl7_r  <= ctx_a[el6_r];
    cr07_r <= ctx_a[er06_r];
    if (ctx_we) begin
      ctx_a[CSW'(wa6_r)] <= ctl_r[6].raw;
    end
  end

  always_ff @(posedge clk) begin
    cr17_r <= ctx_b[er16_r];
    if (ctx_we) begin
      ctx_b[CSW'(wa6_r)] <= ctl_r[6].raw;
    end
  end

  always_ff @(posedge clk) begin
    out_r.initial_state0       <= is7_r[0];
    out_r.initial_state1       <= is7_r[1];
    out_r.final_state0         <= fs7_r[0];
    out_r.final_state1         <= fs7_r[1];
    out_r.final_state2         <= fs7_r[2];
    out_r.final_state3         <= fs7_r[3];
    out_r.left_context_state   <= ctl_r[7].pval ? cl7_r : '0;
    out_r.left_context_valid   <= ctl_r[7].pval;
    out_r.right_context_state0 <= ctl_r[7].nval ? cr07_r : '0;
    out_r.right_context_state1 <= ctl_r[7].nval ? cr17_r : '0;
    out_r.right_context_valid  <= ctl_r[7].nval;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_lookup_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.command == CMD_LOOKUP) |-> ##PIPE_LAT out_valid)
    else $error("lookup produced no result");

  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.command == CMD_WRITE) |-> ##PIPE_LAT !out_valid)
    else $error("write produced a result");

  a_left_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.command == CMD_LOOKUP) |->
    ##PIPE_LAT (out_data.left_context_valid == $past(in_data.prev_valid, PIPE_LAT)))
    else $error("left context flag mismatch");

  a_word_range: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[3] && ctl_r[3].cmd == CMD_LOOKUP) |->
    (ra < MOD_XW'(WORDS)) && (rb < MOD_XW'(WORDS)) && (rc < MOD_XW'(WORDS)))
    else $error("reduced word id out of range");

endmodule
